// ===== sv/rslp_pkg.sv =====
// Shared types and constants of the register script line parser.
// Used by the front classifier queue, the back executor and the top level.
`default_nettype none
package rslp_pkg;

  // Width of the three number accumulators; numbers wrap at this width.
  localparam int NUMBER_WIDTH = 16;
  localparam int CHAR_WIDTH   = 8;
  localparam int FIELD_WIDTH  = 16;

  // Slave addresses that take two data bytes.
  localparam logic [7:0] SLAVE_WIDE_A = 8'h1A;
  localparam logic [7:0] SLAVE_WIDE_B = 8'h1C;

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_W     = 8'h77;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_T     = 8'h74;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_ERROR = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_WAIT  = 2'd3
  } kind_t;

  // One classified script character as it travels from front to back.
  typedef struct packed {
    logic       is_digit;
    logic [3:0] digit;
    logic       is_nl;
    logic       is_stop;   // slash or NUL: rest of line ignored
    logic       is_skip;   // blank, tab, colon, equals
    logic       is_w;
    logic       hit_a;
    logic       hit_i;
    logic       hit_t;
    logic       last;
  } class_t;

endpackage
`default_nettype wire

// ===== sv/rslp_front.sv =====
// Front part: accepts script characters, classifies them and holds them
// in a two-entry queue for the back part. Depends on rslp_pkg.
`default_nettype none
module rslp_front import rslp_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [CHAR_WIDTH-1:0] ch,
  input  wire logic                  last,
  output logic                       q_valid,
  output class_t                     q_item,
  input  wire logic                  q_pop
);

  class_t       entries [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  class_t       cls;
  logic [7:0]   lc;
  logic [7:0]   digit_tmp;
  logic         push;

  // Fold upper case to lower case, then decode.
  always_comb begin
    lc = ((ch >= 8'h41) && (ch <= 8'h5A)) ? (ch | 8'h20) : ch;
    digit_tmp = 8'h00;
    cls.is_digit = 1'b0;
    if ((lc >= 8'h30) && (lc <= 8'h39)) begin
      cls.is_digit = 1'b1;
      digit_tmp = lc - 8'h30;
    end else if ((lc >= CH_A) && (lc <= 8'h66)) begin
      cls.is_digit = 1'b1;
      digit_tmp = lc - 8'h57;
    end
    cls.digit   = digit_tmp[3:0];
    cls.is_nl   = (lc == CH_NL);
    cls.is_stop = (lc == CH_SLASH) || (lc == CH_NUL);
    cls.is_skip = (lc == CH_SPACE) || (lc == CH_TAB) || (lc == CH_COLON) || (lc == CH_EQ);
    cls.is_w    = (lc == CH_W);
    cls.hit_a   = (lc == CH_A);
    cls.hit_i   = (lc == CH_I);
    cls.hit_t   = (lc == CH_T);
    cls.last    = last;
  end

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/rslp_back.sv =====
// Back part: runs the line state machine on classified characters and
// holds each line's command in an output register. Depends on rslp_pkg.
`default_nettype none
module rslp_back import rslp_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   q_valid,
  input  wire class_t                 q_item,
  output logic                        q_pop,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [1:0]                  kind,
  output logic [FIELD_WIDTH-1:0]      slave_addr,
  output logic [FIELD_WIDTH-1:0]      reg_addr,
  output logic [FIELD_WIDTH-1:0]      value,
  output logic [1:0]                  byte_count
);

  typedef enum logic [5:0] {
    PH_SLAVE   = 6'b000001,
    PH_REG     = 6'b000010,
    PH_VALUE   = 6'b000100,
    PH_WRITE   = 6'b001000,
    PH_WAITNUM = 6'b010000,
    PH_WAIT    = 6'b100000
  } phase_t;

  phase_t                  line_phase, line_phase_next;
  logic                    ignore_rest, ignore_rest_next;
  logic                    error_seen, error_seen_next;
  logic                    in_number, in_number_next;
  logic [1:0]              keyword_pos, keyword_pos_next;
  logic [NUMBER_WIDTH-1:0] slave_acc, slave_acc_next;
  logic [NUMBER_WIDTH-1:0] reg_acc, reg_acc_next;
  logic [NUMBER_WIDTH-1:0] value_acc, value_acc_next;

  logic                    ends_line;
  logic                    tail_hit;
  kind_t                   kind_res;
  phase_t                  ph_end;
  logic                    err_end;

  function automatic phase_t advance(input phase_t ph);
    phase_t r;
    unique case (ph)
      PH_SLAVE:   r = PH_REG;
      PH_REG:     r = PH_VALUE;
      PH_VALUE:   r = PH_WRITE;
      PH_WAITNUM: r = PH_WAIT;
      default:    r = ph;
    endcase
    return r;
  endfunction

  function automatic logic [FIELD_WIDTH-1:0] to_field(input logic [NUMBER_WIDTH-1:0] a);
    logic [31:0] w;
    w = 32'(a);
    return w[FIELD_WIDTH-1:0];
  endfunction

  assign ends_line = q_item.is_nl || q_item.last;
  // A line end needs the output register; anything else never stalls.
  assign q_pop = q_valid && (!ends_line || !out_valid || out_ready);

  always_comb begin
    unique case (keyword_pos)
      2'd1:    tail_hit = q_item.hit_a;
      2'd2:    tail_hit = q_item.hit_i;
      2'd3:    tail_hit = q_item.hit_t;
      default: tail_hit = 1'b0;
    endcase
  end

  always_comb begin
    line_phase_next  = line_phase;
    ignore_rest_next = ignore_rest;
    error_seen_next  = error_seen;
    in_number_next   = in_number;
    keyword_pos_next = keyword_pos;
    slave_acc_next   = slave_acc;
    reg_acc_next     = reg_acc;
    value_acc_next   = value_acc;

    if (ignore_rest || error_seen) begin
      // Characters are dropped until the line ends.
    end else if (in_number) begin
      if (q_item.is_digit) begin
        unique case (line_phase)
          PH_SLAVE: slave_acc_next = {slave_acc[NUMBER_WIDTH-5:0], q_item.digit};
          PH_REG:   reg_acc_next   = {reg_acc[NUMBER_WIDTH-5:0], q_item.digit};
          default:  value_acc_next = {value_acc[NUMBER_WIDTH-5:0], q_item.digit};
        endcase
      end else begin
        // The character after a number is swallowed unseen.
        in_number_next  = 1'b0;
        line_phase_next = advance(line_phase);
      end
    end else if (keyword_pos != 2'd0) begin
      if (tail_hit) begin
        keyword_pos_next = keyword_pos + 2'd1;
        if (keyword_pos == 2'd3) begin
          line_phase_next = PH_WAITNUM;
        end
      end else begin
        keyword_pos_next = 2'd0;
        error_seen_next  = 1'b1;
      end
    end else if (q_item.is_nl) begin
      // Handled as a line end below.
    end else if (q_item.is_stop) begin
      ignore_rest_next = 1'b1;
    end else if (q_item.is_skip) begin
      // Separator.
    end else if (q_item.is_w) begin
      keyword_pos_next = 2'd1;
    end else if (q_item.is_digit) begin
      in_number_next = 1'b1;
      unique case (line_phase)
        PH_SLAVE: slave_acc_next = NUMBER_WIDTH'(q_item.digit);
        PH_REG:   reg_acc_next   = NUMBER_WIDTH'(q_item.digit);
        default:  value_acc_next = NUMBER_WIDTH'(q_item.digit);
      endcase
    end else begin
      error_seen_next = 1'b1;
    end

    // Line end: close an open number, flag an unfinished keyword.
    ph_end  = in_number_next ? advance(line_phase_next) : line_phase_next;
    err_end = error_seen_next || (keyword_pos_next != 2'd0);
    if (err_end) begin
      kind_res = KIND_ERROR;
    end else if (ph_end == PH_WRITE) begin
      kind_res = KIND_WRITE;
    end else if (ph_end == PH_WAIT) begin
      kind_res = KIND_WAIT;
    end else begin
      kind_res = KIND_NONE;
    end

    if (ends_line) begin
      line_phase_next  = PH_SLAVE;
      ignore_rest_next = 1'b0;
      error_seen_next  = 1'b0;
      in_number_next   = 1'b0;
      keyword_pos_next = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_phase  <= PH_SLAVE;
      ignore_rest <= 1'b0;
      error_seen  <= 1'b0;
      in_number   <= 1'b0;
      keyword_pos <= 2'd0;
      slave_acc   <= '0;
      reg_acc     <= '0;
      value_acc   <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (q_pop) begin
        line_phase  <= line_phase_next;
        ignore_rest <= ignore_rest_next;
        error_seen  <= error_seen_next;
        in_number   <= in_number_next;
        keyword_pos <= keyword_pos_next;
        slave_acc   <= slave_acc_next;
        reg_acc     <= reg_acc_next;
        value_acc   <= value_acc_next;
      end
      if (q_pop && ends_line) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && ends_line) begin
      kind       <= kind_res;
      slave_addr <= to_field(slave_acc_next);
      reg_addr   <= to_field(reg_acc_next);
      value      <= to_field(value_acc_next);
      byte_count <= ((slave_acc_next == NUMBER_WIDTH'(SLAVE_WIDE_A)) ||
                     (slave_acc_next == NUMBER_WIDTH'(SLAVE_WIDE_B))) ? 2'd2 : 2'd1;
    end
  end

endmodule
`default_nettype wire

// ===== sv/register_script_line_parser.sv =====
// Register script line parser: one script character in per word, one
// command out per line. The input channel (in_valid, in_ready, ch, last)
// carries a raw character and a flag that marks the end of the script.
// The output channel (out_valid, out_ready, kind, slave_addr, reg_addr,
// value, byte_count) carries one command word for each newline or last
// character; all other characters produce no output word.
// Throughput is one character per cycle while no line end waits for the output
// register. The front classifies each word into a two-entry queue, and the back
// updates the line state and the number accumulators for each word it pops, so
// the line state loop sets that figure. The word that ends a line is written
// into the queue, then popped by the back, which registers the line's command.
// Reset (rst, synchronous, active high) empties the queue and the output
// register, clears the accumulators and returns to the start of a line.
// While the receiver holds out_ready low with a command waiting, the back
// keeps consuming characters that do not end a line; a line end then waits
// in the queue, and once the queue fills, in_ready drops.
// Depends on rslp_pkg, rslp_front and rslp_back.
`default_nettype none
module register_script_line_parser import rslp_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [CHAR_WIDTH-1:0]  ch,
  input  wire logic                   last,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [1:0]                  kind,
  output logic [FIELD_WIDTH-1:0]      slave_addr,
  output logic [FIELD_WIDTH-1:0]      reg_addr,
  output logic [FIELD_WIDTH-1:0]      value,
  output logic [1:0]                  byte_count
);

  // Queue handshake between the two halves.
  logic   q_valid;
  logic   q_pop;
  class_t q_item;

  rslp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .ch       (ch),
    .last     (last),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  rslp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .slave_addr (slave_addr),
    .reg_addr   (reg_addr),
    .value      (value),
    .byte_count (byte_count)
  );

endmodule
`default_nettype wire
